/* rtl/imu_sensor_report_parser_unit_assert.svh */
// Assertion macros shared by the parser RTL.
`ifndef IMU_SENSOR_REPORT_PARSER_UNIT_ASSERT_SVH
`define IMU_SENSOR_REPORT_PARSER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define ISRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define ISRP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/isrp_pkg.sv */
// Types, report codes and decode functions of the sensor report parser.
package isrp_pkg;

  localparam logic [7:0] RID_TS_BASE  = 8'hFB;
  localparam logic [7:0] RID_TS_DELTA = 8'hFA;
  localparam logic [7:0] RID_FLUSH    = 8'hEF;
  localparam logic [7:0] RID_ACCEL    = 8'h01;
  localparam logic [7:0] RID_GYRO     = 8'h02;
  localparam logic [7:0] RID_MAG      = 8'h03;
  localparam logic [7:0] RID_ROT      = 8'h05;

  localparam logic [2:0] KIND_ACCEL = 3'd0;
  localparam logic [2:0] KIND_GYRO  = 3'd1;
  localparam logic [2:0] KIND_MAG   = 3'd2;
  localparam logic [2:0] KIND_ROT   = 3'd3;
  localparam logic [2:0] KIND_BAD   = 3'd4;

  localparam logic [3:0] FRAC_ACCEL = 4'd8;
  localparam logic [3:0] FRAC_GYRO  = 4'd9;
  localparam logic [3:0] FRAC_MAG   = 4'd4;
  localparam logic [3:0] FRAC_ROT   = 4'd14;

  localparam logic [7:0] CHANNEL_RESET = 8'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  report_kind;
    logic [15:0] x_value;
    logic [15:0] y_value;
    logic [15:0] z_value;
    logic [15:0] w_value;
    logic [3:0]  frac_bits;
  } result_t;

  // Report length in bytes, zero for an unknown id.
  function automatic logic [3:0] report_span(input logic [7:0] id);
    logic [3:0] s;
    begin
      case (id)
        RID_TS_BASE, RID_TS_DELTA: s = 4'd5;
        RID_FLUSH:                 s = 4'd2;
        RID_ACCEL, RID_GYRO, RID_MAG: s = 4'd10;
        RID_ROT:                   s = 4'd14;
        default:                   s = 4'd0;
      endcase
      return s;
    end
  endfunction

endpackage

/* rtl/isrp_in_reg.sv */
// Input register: holds one accepted byte until the parse stage takes it.
module isrp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  isrp_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output isrp_pkg::in_item_t item
);

  logic               valid_r;
  isrp_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/isrp_parse_core.sv */
// Packet header and report parser state with per-byte next-state logic.
module isrp_parse_core #(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  isrp_pkg::in_item_t item,
  input  logic [7:0]         report_channel,
  output isrp_pkg::result_t  result
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [14:0] MaxLen = 15'(MAX_PACKET_BYTES);
  localparam logic [PW-1:0] PosOne   = PW'(1);
  localparam logic [PW-1:0] PosTwo   = PW'(2);
  localparam logic [PW-1:0] HdrBytes = PW'(4);

  typedef enum logic [1:0] {MODE_IDLE, MODE_HEADER, MODE_PAYLOAD} mode_t;

  mode_t          mode_r, mode_nxt, mode_v;
  logic [PW-1:0]  pos_r, pos_nxt, pos_v, pos_inc;
  logic [PW-1:0]  len_r, len_nxt;
  logic [7:0]     chan_r, chan_nxt;
  logic [7:0]     rid_r, rid_nxt, rid_v;
  logic [3:0]     off_r, off_nxt, off_v, span_v;
  logic [7:0]     low_r, low_nxt;
  logic [15:0]    axis_r [4];
  logic [15:0]    axis_nxt [4];
  logic [14:0]    len15;
  logic [1:0]     axis_idx;
  logic [7:0]     b;

  assign b = item.rx_byte;

  always_comb begin
    mode_v   = item.packet_start ? MODE_HEADER : mode_r;
    pos_v    = item.packet_start ? '0 : pos_r;
    off_v    = item.packet_start ? 4'd0 : off_r;
    pos_inc  = pos_v + PosOne;
    len15    = {b[6:0], low_r};
    rid_v    = (off_v == 4'd0) ? b : rid_r;
    span_v   = isrp_pkg::report_span(rid_v);
    axis_idx = 2'(off_v[3:1] - 3'd2);

    mode_nxt = mode_v;
    pos_nxt  = pos_v;
    off_nxt  = off_v;
    len_nxt  = len_r;
    chan_nxt = chan_r;
    rid_nxt  = rid_r;
    low_nxt  = low_r;
    for (int i = 0; i < 4; i++) axis_nxt[i] = axis_r[i];
    result   = '0;

    case (mode_v)
      MODE_HEADER: begin
        pos_nxt = pos_inc;
        if (pos_v == '0) begin
          low_nxt = b;
        end else if (pos_v == PosOne) begin
          len_nxt = PW'(len15);
          if (len15 < 15'd4 || len15 > MaxLen) begin
            mode_nxt           = MODE_IDLE;
            result.valid       = 1'b1;
            result.report_kind = isrp_pkg::KIND_BAD;
          end
        end else if (pos_v == PosTwo) begin
          chan_nxt = b;
        end else if (chan_r != report_channel || len_r <= HdrBytes) begin
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_PAYLOAD;
          off_nxt  = 4'd0;
        end
      end
      MODE_PAYLOAD: begin
        pos_nxt = pos_inc;
        if (span_v == 4'd0) begin
          // unknown id at a report boundary ends the packet
          mode_nxt = MODE_IDLE;
        end else begin
          rid_nxt = rid_v;
          if (span_v >= 4'd10 && off_v >= 4'd4 && off_v <= 4'd11) begin
            if (!off_v[0]) begin
              low_nxt = b;
            end else begin
              axis_nxt[axis_idx] = {b, low_r};
            end
          end
          if ({1'b0, off_v} + 5'd1 >= {1'b0, span_v}) begin
            off_nxt          = 4'd0;
            result.x_value   = axis_nxt[0];
            result.y_value   = axis_nxt[1];
            result.z_value   = axis_nxt[2];
            case (rid_v)
              isrp_pkg::RID_ACCEL: begin
                result.valid       = 1'b1;
                result.report_kind = isrp_pkg::KIND_ACCEL;
                result.frac_bits   = isrp_pkg::FRAC_ACCEL;
              end
              isrp_pkg::RID_GYRO: begin
                result.valid       = 1'b1;
                result.report_kind = isrp_pkg::KIND_GYRO;
                result.frac_bits   = isrp_pkg::FRAC_GYRO;
              end
              isrp_pkg::RID_MAG: begin
                result.valid       = 1'b1;
                result.report_kind = isrp_pkg::KIND_MAG;
                result.frac_bits   = isrp_pkg::FRAC_MAG;
              end
              isrp_pkg::RID_ROT: begin
                result.valid       = 1'b1;
                result.report_kind = isrp_pkg::KIND_ROT;
                result.w_value     = axis_nxt[3];
                result.frac_bits   = isrp_pkg::FRAC_ROT;
              end
              default: begin
                result.valid = 1'b0;
              end
            endcase
          end else begin
            off_nxt = off_v + 4'd1;
          end
        end
        if (pos_inc >= len_r) begin
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      len_r  <= '0;
      chan_r <= '0;
      rid_r  <= '0;
      off_r  <= '0;
      low_r  <= '0;
      for (int i = 0; i < 4; i++) axis_r[i] <= '0;
    end else if (go) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      chan_r <= chan_nxt;
      rid_r  <= rid_nxt;
      off_r  <= off_nxt;
      low_r  <= low_nxt;
      for (int i = 0; i < 4; i++) axis_r[i] <= axis_nxt[i];
    end
  end

endmodule

/* rtl/imu_sensor_report_parser_unit.sv */
// Top level of the sensor-hub input report parser.
//
// Usage: packet bytes enter on the in_ stream, one item per byte; in_tuser is
// high on the first header byte of each packet. Header: 15-bit little-endian
// length (continuation bit masked), channel, sequence. Packets on the channel
// held in the cfg_ register (reset 3) are walked as a chain of reports.
// Accel, gyro, magnetometer and rotation-vector reports each give one item on
// the out_ stream with raw fixed-point values; a length under 4 or above
// MAX_PACKET_BYTES gives one bad-header item.
// The parse logic sits between the input register and the output register;
// an item waits in the input register while the output register stalls.
// Throughput: one byte per cycle while the output register is free or drains.
// Stalls: the output register holds a result until out_tready; the input
// register keeps taking bytes while the output register is free or drains,
// so in_tready drops only when a result is waiting and a byte is held.
// Reset: synchronous, active low; parser idle, no result pending, channel 3.
// Configuration must be written only while no item is in flight; unenforced.
module imu_sensor_report_parser_unit #(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] packet_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [15:0] x, [31:16] y, [47:32] z, [63:48] w,
                                  // [67:64] frac_bits, [71:68] zero
  output logic [2:0]  out_tuser,  // [2:0] report_kind
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data // [7:0] report_channel
);

  logic               advance, item_valid, go;
  isrp_pkg::in_item_t in_item, item;
  isrp_pkg::result_t  result;
  logic [7:0]         channel_r;
  logic               out_valid_r;
  isrp_pkg::result_t  out_r;
  logic               out_bad, out_not_rot;

  assign in_item.rx_byte      = in_tdata;
  assign in_item.packet_start = in_tuser;

  assign advance = !out_valid_r || out_tready;
  assign go      = item_valid && advance;

  isrp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  isrp_parse_core #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (go),
    .item           (item),
    .report_channel (channel_r),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r <= isrp_pkg::CHANNEL_RESET;
    end else if (cfg_wr_en) begin
      channel_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= go && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && go && result.valid) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.report_kind;
  assign out_tdata  = {4'd0, out_r.frac_bits, out_r.w_value, out_r.z_value,
                       out_r.y_value, out_r.x_value};

  assign out_bad     = out_tvalid && out_tuser == isrp_pkg::KIND_BAD;
  assign out_not_rot = out_tvalid && out_tuser != isrp_pkg::KIND_ROT;

`include "imu_sensor_report_parser_unit_assert.svh"

  `ISRP_ASSERT_RST(a_no_out_after_reset, !rst_n |=> !out_tvalid, "result valid after reset")
  `ISRP_ASSERT(a_bad_hdr_zero, out_bad |-> out_tdata == '0, "bad header carries data")
  `ISRP_ASSERT(a_w_only_rot, out_not_rot |-> out_tdata[63:48] == '0, "w set on non-quaternion")
  `ISRP_ASSERT(a_stall_cause, !in_tready |-> out_tvalid && !out_tready, "stall without cause")

endmodule

/* test/tb.sv */
// Testbench for the sensor report parser: packet streams, self-checking against a local predictor.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_LEN = 512;
  localparam int LIMIT = 300000;
  localparam int LONG_HOLD = 300;
  localparam logic [7:0] RID_UNKNOWN = 8'h00;

  typedef enum logic [1:0] {P_IDLE, P_HEADER, P_PAYLOAD} parse_mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] w;
    logic [3:0]  frac;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;

  isrp_pkg::in_item_t bytes_to_send[$];
  report_t     reports_due[$];
  logic [7:0]  body[$];
  int          items_queued = 0;
  int          errors = 0;
  int unsigned cycles = 0;
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          hold_asked = 0;
  int          hold_taken = 0;
  int          hold_left = 0;

  // predictor state
  logic [7:0]  chan_reg = isrp_pkg::CHANNEL_RESET;
  parse_mode_t mode = P_IDLE;
  int          pos = 0;
  logic [14:0] plen = '0;
  logic [7:0]  pchan = '0;
  logic [7:0]  rid = '0;
  logic [3:0]  roff = '0;
  logic [7:0]  lowb = '0;
  logic [15:0] axes[4] = '{default: '0};

  imu_sensor_report_parser_unit #(.MAX_PACKET_BYTES(MAX_LEN)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int rep_len(input logic [7:0] id);
    case (id)
      isrp_pkg::RID_TS_BASE, isrp_pkg::RID_TS_DELTA: return 5;
      isrp_pkg::RID_FLUSH: return 2;
      isrp_pkg::RID_ACCEL, isrp_pkg::RID_GYRO, isrp_pkg::RID_MAG: return 10;
      isrp_pkg::RID_ROT: return 14;
      default: return 0;
    endcase
  endfunction

  function automatic void push_report(input logic [2:0] k, input logic [15:0] wv,
                                      input logic [3:0] f);
    report_t r;
    r.kind = k;
    r.x = axes[0];
    r.y = axes[1];
    r.z = axes[2];
    r.w = wv;
    r.frac = f;
    reports_due.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic st);
    logic [14:0] len;
    int off;
    int span;
    report_t bad;
    if (st) begin
      mode = P_HEADER;
      pos = 0;
      roff = '0;
    end
    if (mode == P_IDLE) return;
    if (mode == P_HEADER) begin
      case (pos)
        0: lowb = b;
        1: begin
          len = {b[6:0], lowb};
          plen = len;
          if (len < 4 || len > MAX_LEN) begin
            bad = '0;
            bad.kind = isrp_pkg::KIND_BAD;
            reports_due.push_back(bad);
            mode = P_IDLE;
            return;
          end
        end
        2: pchan = b;
        default: begin
          if (pchan != chan_reg || plen <= 4) mode = P_IDLE;
          else begin
            mode = P_PAYLOAD;
            roff = '0;
          end
        end
      endcase
      pos = pos + 1;
      return;
    end
    off = roff;
    if (off == 0) begin
      if (rep_len(b) == 0) begin
        mode = P_IDLE;
        return;
      end
      rid = b;
    end
    span = rep_len(rid);
    if (span >= 10 && off >= 4 && off <= 11) begin
      if (off % 2 == 0) lowb = b;
      else axes[(off - 4) / 2] = {b, lowb};
    end
    if (off + 1 >= span) begin
      roff = '0;
      case (rid)
        isrp_pkg::RID_ACCEL:
          push_report(isrp_pkg::KIND_ACCEL, 16'd0, isrp_pkg::FRAC_ACCEL);
        isrp_pkg::RID_GYRO:
          push_report(isrp_pkg::KIND_GYRO, 16'd0, isrp_pkg::FRAC_GYRO);
        isrp_pkg::RID_MAG:
          push_report(isrp_pkg::KIND_MAG, 16'd0, isrp_pkg::FRAC_MAG);
        isrp_pkg::RID_ROT:
          push_report(isrp_pkg::KIND_ROT, axes[3], isrp_pkg::FRAC_ROT);
        default: ;
      endcase
    end else begin
      roff = 4'(off + 1);
    end
    pos = pos + 1;
    if (pos >= plen) mode = P_IDLE;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic st);
    isrp_pkg::in_item_t it;
    it.rx_byte = b;
    it.packet_start = st;
    bytes_to_send.push_back(it);
    items_queued++;
  endtask

  // Appends one report to the payload under construction.
  task automatic put_report(input logic [7:0] id, input logic [15:0] xv, input logic [15:0] yv,
                            input logic [15:0] zv, input logic [15:0] wv);
    logic [7:0] r[$];
    logic [15:0] words[4];
    int n;
    words = '{xv, yv, zv, wv};
    n = rep_len(id);
    if (n == 0) n = 3;
    r.push_back(id);
    repeat (3) r.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) begin
      r.push_back(words[i][7:0]);
      r.push_back(words[i][15:8]);
    end
    while (r.size() > n) void'(r.pop_back());
    while (r.size() < n) r.push_back(8'($urandom));
    foreach (r[i]) body.push_back(r[i]);
  endtask

  task automatic put_packet(input int len, input bit cont, input logic [7:0] ch);
    logic [14:0] l;
    l = 15'(len);
    push_byte(l[7:0], 1'b1);
    push_byte({cont, l[14:8]}, 1'b0);
    push_byte(ch, 1'b0);
    push_byte(8'($urandom), 1'b0);
    foreach (body[i]) push_byte(body[i], 1'b0);
    body.delete();
  endtask

  function automatic logic [7:0] pick_id();
    logic [7:0] id;
    case ($urandom_range(0, 15))
      0, 1:     id = isrp_pkg::RID_TS_BASE;
      2:        id = isrp_pkg::RID_TS_DELTA;
      3:        id = isrp_pkg::RID_FLUSH;
      4, 5, 6:  id = isrp_pkg::RID_ACCEL;
      7, 8, 9:  id = isrp_pkg::RID_GYRO;
      10, 11, 12: id = isrp_pkg::RID_MAG;
      13, 14:   id = isrp_pkg::RID_ROT;
      default: begin
        do id = 8'($urandom); while (rep_len(id) != 0);
      end
    endcase
    return id;
  endfunction

  task automatic gen_packet(input logic [7:0] ch);
    int len;
    int style;
    repeat ($urandom_range(1, 4))
      put_report(pick_id(), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    len = 4 + body.size();
    style = $urandom_range(0, 9);
    if (style == 0) len = len - $urandom_range(1, 6);
    else if (style == 1) len = len + $urandom_range(1, 12);
    else if (style == 2) repeat ($urandom_range(1, 6)) body.push_back(8'($urandom));
    put_packet(len, 1'($urandom), ch);
  endtask

  task automatic random_traffic(input int n);
    int goal;
    int r;
    goal = items_queued + n;
    while (items_queued < goal) begin
      r = $urandom_range(0, 99);
      if (r < 75) gen_packet(chan_reg);
      else if (r < 85) gen_packet(chan_reg ^ 8'($urandom_range(1, 255)));
      else if (r < 93) begin
        if ($urandom_range(0, 1) == 0) put_packet($urandom_range(0, 3), 1'($urandom), chan_reg);
        else put_packet($urandom_range(MAX_LEN + 1, 32767), 1'($urandom), chan_reg);
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic directed();
    push_byte(8'hFF, 1'b0);
    put_packet(0, 1'b0, chan_reg);
    put_packet(3, 1'b1, chan_reg);
    put_packet(MAX_LEN + 1, 1'b0, chan_reg);
    put_packet(32767, 1'b0, chan_reg);
    put_packet(4, 1'b0, chan_reg);
    put_report(isrp_pkg::RID_ACCEL, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
    put_report(isrp_pkg::RID_GYRO, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_report(isrp_pkg::RID_TS_BASE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_report(isrp_pkg::RID_MAG, 16'h0001, 16'hFFFE, 16'h7FFF, 16'h0000);
    put_report(isrp_pkg::RID_TS_DELTA, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_report(isrp_pkg::RID_FLUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_report(isrp_pkg::RID_ROT, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    put_packet(4 + body.size(), 1'b1, chan_reg);
    put_report(isrp_pkg::RID_ACCEL, 16'h1234, 16'h5678, 16'h9ABC, 16'h0000);
    put_packet(4 + body.size(), 1'b0, chan_reg + 8'd1);
    put_report(RID_UNKNOWN, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_report(isrp_pkg::RID_ACCEL, 16'h1111, 16'h2222, 16'h3333, 16'h0000);
    put_packet(4 + body.size(), 1'b0, chan_reg);
    // truncated report, then bytes past the length
    put_report(isrp_pkg::RID_ACCEL, 16'h4444, 16'h5555, 16'h6666, 16'h0000);
    put_packet(10, 1'b0, chan_reg);
    // maximum length, cut short by the next start
    put_report(isrp_pkg::RID_FLUSH, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    put_report(isrp_pkg::RID_GYRO, 16'hFFFF, 16'h8000, 16'h0001, 16'h0000);
    put_packet(MAX_LEN, 1'b1, chan_reg);
    put_report(isrp_pkg::RID_MAG, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
    put_packet(4 + body.size(), 1'b0, chan_reg);
  endtask

  task automatic drain();
    do @(negedge clk); while (bytes_to_send.size() != 0 || in_tvalid || reports_due.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_channel(input logic [7:0] ch);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ch;
    chan_reg = ch;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int gap, input int stall);
    send_gap_pct = gap;
    stall_pct = stall;
  endtask

  // sender
  always @(posedge clk) begin
    isrp_pkg::in_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) parse_byte(in_tdata, in_tuser);
      if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        it = bytes_to_send.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= it.rx_byte;
        in_tuser <= it.packet_start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      hold_left <= LONG_HOLD;
      hold_taken <= hold_taken + 1;
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && hold_left == 0 && $urandom_range(0, 99) >= stall_pct;
  end

  // result checker
  always @(posedge clk) begin
    report_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (reports_due.size() == 0) begin
        report_mismatch("unexpected result, kind", 16'(out_tuser), 16'd0);
      end else begin
        e = reports_due.pop_front();
        if (out_tuser != e.kind) report_mismatch("report_kind", 16'(out_tuser), 16'(e.kind));
        if (out_tdata[15:0] != e.x) report_mismatch("x_value", out_tdata[15:0], e.x);
        if (out_tdata[31:16] != e.y) report_mismatch("y_value", out_tdata[31:16], e.y);
        if (out_tdata[47:32] != e.z) report_mismatch("z_value", out_tdata[47:32], e.z);
        if (out_tdata[63:48] != e.w) report_mismatch("w_value", out_tdata[63:48], e.w);
        if (out_tdata[67:64] != e.frac)
          report_mismatch("frac_bits", 16'(out_tdata[67:64]), 16'(e.frac));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, reports_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_idling(0, 0);
    directed();
    drain();

    set_channel(8'd0);
    hold_asked = hold_asked + 1;
    random_traffic(450);
    drain();

    set_channel(8'd255);
    set_idling(73, 0);
    random_traffic(450);
    drain();

    set_channel(8'($urandom));
    set_idling(0, 73);
    random_traffic(450);
    drain();

    set_channel(isrp_pkg::CHANNEL_RESET);
    set_idling(14, 14);
    random_traffic(450);
    drain();

    if (errors == 0 && reports_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
